// File: rtl/core/ftp_pkg.sv
// Shared types and constants for the force-to-pwm interpolator.
// No dependencies.
`timescale 1ns / 1ps
package ftp_pkg;
    localparam logic [1:0] CFG_PWM_MIN     = 2'd0;
    localparam logic [1:0] CFG_PWM_MAX     = 2'd1;
    localparam logic [1:0] CFG_ENTRY_COUNT = 2'd2;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_CONVERT = 1'b1;

    typedef struct packed {
        logic load_wr;
        logic start_rd;
        logic next_rd;
        logic mul;
        logic div_start;
        logic finish;
    } ftp_cmd_t;

    typedef struct packed {
        logic hit;
        logic last;
        logic at_first;
        logic div_done;
    } ftp_stat_t;
endpackage

// File: rtl/core/force_to_pwm_interpolator_top.sv
// Channel  | signals                                              | dir
// in       | in_valid in_ready action entry_index entry_force ... | in
// out      | out_valid out_ready pwm was_clamped table_empty      | out
// cfg      | cfg_we cfg_index cfg_data                            | in
// Load writes the table; an empty-table convert finishes when accepted. Other converts
// search the entries in order (registered memory read per entry), then take the first or
// last pwm, or interpolate (subtract, multiply, bit-serial divide); the result is clamped.
// Reset clears control, sets pwm min/max to 1100/1900 and entry count to 0; table contents are undefined until written.
// Input stalls while the single output register is full.
`timescale 1ns / 1ps
module force_to_pwm_interpolator_top
#(
    parameter int TABLE_DEPTH = 64,
    parameter int FORCE_FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic [5:0]         entry_index,
    input  logic signed [31:0] entry_force,
    input  logic [15:0]        entry_pwm,
    input  logic signed [31:0] force_req,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        pwm,
    output logic               was_clamped,
    output logic               table_empty,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    localparam int IW = (TABLE_DEPTH > 64) ? $clog2(TABLE_DEPTH) : 6;
    logic [15:0] pmin_reg, pmax_reg;
    logic [6:0]  cnt_reg;
    logic [IW:0] count;
    logic        empty;
    ftp_pkg::ftp_cmd_t  cmd;
    ftp_pkg::ftp_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pmin_reg <= 16'd1100;
            pmax_reg <= 16'd1900;
            cnt_reg <= 7'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ftp_pkg::CFG_PWM_MIN:     pmin_reg <= cfg_data;
                ftp_pkg::CFG_PWM_MAX:     pmax_reg <= cfg_data;
                ftp_pkg::CFG_ENTRY_COUNT: cnt_reg <= cfg_data[6:0];
                default:                  ;
            endcase
        end
    end

    assign count = (32'(cnt_reg) > TABLE_DEPTH) ? (IW+1)'(TABLE_DEPTH) : (IW+1)'(cnt_reg);
    assign empty = cnt_reg == 7'd0;

    ftp_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .action(action),
        .empty(empty), .out_busy(out_valid), .in_ready(in_ready),
        .cmd(cmd), .stat(stat)
    );

    ftp_dp #(.DEPTH(TABLE_DEPTH), .IW(IW)) u_dp
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .entry_index(IW'(entry_index)), .entry_force(entry_force),
        .entry_pwm(entry_pwm), .force_req(force_req), .pwm_min(pmin_reg),
        .pwm_max(pmax_reg), .count(count), .empty(empty), .out_ready(out_ready),
        .out_valid(out_valid), .pwm(pwm), .was_clamped(was_clamped),
        .table_empty(table_empty)
    );

`ifndef ASSERT_OFF
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_empty |-> !was_clamped)
        else $error("empty result flagged clamped");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("accept while output full");
`endif
endmodule

// File: rtl/core/ftp_ctrl.sv
// Controller state machine for the force-to-pwm interpolator.
// Depends on ftp_pkg.
`timescale 1ns / 1ps
module ftp_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              action,
    input  logic              empty,
    input  logic              out_busy,
    output logic              in_ready,
    output ftp_pkg::ftp_cmd_t cmd,
    input  ftp_pkg::ftp_stat_t stat
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_WAIT = 3'd5;

    logic [2:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE) && !out_busy;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (action == ftp_pkg::ACT_LOAD)
                        cmd.load_wr = 1'b1;
                    else if (empty)
                        cmd.finish = 1'b1;
                    else
                    begin
                        cmd.start_rd = 1'b1;
                        state_next = S_WAIT;
                    end
                end
            end
            S_WAIT:
            begin
                state_next = S_SRCH;
            end
            S_SRCH:
            begin
                if (stat.hit || stat.last)
                begin
                    if (stat.at_first || !stat.hit)
                        state_next = S_FIN;
                    else
                        state_next = S_MUL;
                end
                else
                begin
                    cmd.next_rd = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (stat.div_done && !out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

// File: rtl/core/ftp_dp.sv
// Datapath: breakpoint memory, search pointer, multiplier, divider, clamp.
// Depends on ftp_pkg.
`timescale 1ns / 1ps
module ftp_dp
#(
    parameter int DEPTH = 64,
    parameter int IW    = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ftp_pkg::ftp_cmd_t cmd,
    output ftp_pkg::ftp_stat_t stat,
    input  logic [IW-1:0]     entry_index,
    input  logic signed [31:0] entry_force,
    input  logic [15:0]       entry_pwm,
    input  logic signed [31:0] force_req,
    input  logic [15:0]       pwm_min,
    input  logic [15:0]       pwm_max,
    input  logic [IW:0]       count,
    input  logic              empty,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [15:0]       pwm,
    output logic              was_clamped,
    output logic              table_empty
);
    logic signed [31:0] mem_f [DEPTH];
    logic [15:0]        mem_p [DEPTH];
    logic signed [31:0] rd_f_reg;
    logic [15:0]        rd_p_reg;
    logic [IW:0]        ptr_reg;
    logic signed [31:0] req_reg, f1_reg;
    logic [15:0]        p1_reg;
    logic signed [17:0] val_reg;
    logic signed [16:0] dp_reg;
    logic signed [32:0] df_reg, dn_reg;
    logic signed [50:0] prod_reg;
    logic [50:0]        rem_reg;
    logic [50:0]        quo_reg;
    logic [32:0]        dvs_reg;
    logic               neg_reg, divb_reg;
    logic [5:0]         dcnt_reg;
    logic               ov_reg;
    logic [15:0]        po_reg;
    logic               pc_reg, pe_reg;

    assign stat.hit = rd_f_reg >= req_reg;
    assign stat.last = (ptr_reg + 1'b1) == count;
    assign stat.at_first = ptr_reg == '0;
    assign stat.div_done = !divb_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && (32'(entry_index) < DEPTH))
        begin
            mem_f[entry_index] <= entry_force;
            mem_p[entry_index] <= entry_pwm;
        end
        if (cmd.start_rd || cmd.next_rd)
        begin
            rd_f_reg <= mem_f[cmd.start_rd ? '0 : ptr_reg[IW-1:0] + 1'b1];
            rd_p_reg <= mem_p[cmd.start_rd ? '0 : ptr_reg[IW-1:0] + 1'b1];
        end
    end

    logic [51:0] trial;
    assign trial = {rem_reg, quo_reg[50]} - {19'd0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divb_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start_rd)
            begin
                ptr_reg <= '0;
                req_reg <= force_req;
            end
            if (cmd.next_rd)
            begin
                ptr_reg <= ptr_reg + 1'b1;
                f1_reg <= rd_f_reg;
                p1_reg <= rd_p_reg;
            end
            if (!cmd.next_rd && !cmd.start_rd && !cmd.mul && !divb_reg)
                val_reg <= {2'b00, rd_p_reg};
            if (cmd.mul)
            begin
                dp_reg <= $signed({1'b0, rd_p_reg}) - $signed({1'b0, p1_reg});
                dn_reg <= 33'(req_reg) - 33'(f1_reg);
                df_reg <= 33'(rd_f_reg) - 33'(f1_reg);
            end
            if (cmd.div_start)
            begin
                prod_reg <= 51'(dp_reg) * 51'(dn_reg);
                divb_reg <= 1'b1;
                dcnt_reg <= 6'd0;
                dvs_reg <= df_reg[32:0];
            end
            else if (divb_reg)
            begin
                if (dcnt_reg == 6'd0)
                begin
                    neg_reg <= prod_reg[50];
                    quo_reg <= prod_reg[50] ? 51'(-prod_reg) : prod_reg;
                    rem_reg <= '0;
                    dcnt_reg <= 6'd1;
                end
                else if (dcnt_reg <= 6'd51)
                begin
                    if (!trial[51])
                    begin
                        rem_reg <= trial[50:0];
                        quo_reg <= {quo_reg[49:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[49:0], quo_reg[50]};
                        quo_reg <= {quo_reg[49:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 6'd1;
                end
                else
                begin
                    divb_reg <= 1'b0;
                    if (neg_reg)
                        val_reg <= 18'($signed({2'b00, p1_reg}))
                            - 18'(quo_reg + ((rem_reg != 0) ? 51'd1 : 51'd0));
                    else
                        val_reg <= 18'($signed({2'b00, p1_reg})) + 18'(quo_reg);
                end
            end
            if (cmd.finish)
                ov_reg <= 1'b1;
            else if (ov_reg && out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            pe_reg <= empty;
            if (empty)
            begin
                po_reg <= pwm_min;
                pc_reg <= 1'b0;
            end
            else if (val_reg < $signed({2'b00, pwm_min}))
            begin
                po_reg <= pwm_min;
                pc_reg <= 1'b1;
            end
            else if (val_reg > $signed({2'b00, pwm_max}))
            begin
                po_reg <= pwm_max;
                pc_reg <= 1'b1;
            end
            else
            begin
                po_reg <= val_reg[15:0];
                pc_reg <= 1'b0;
            end
        end
    end

    assign out_valid = ov_reg;
    assign pwm = po_reg;
    assign was_clamped = pc_reg;
    assign table_empty = pe_reg;
endmodule
